/* rtl/psd_pkg.sv */
// Shared constants, types and the signature table of the palette image stream decoder.
`default_nettype none

package psd_pkg;

    localparam int IMAGE_SIDE  = 1024;
    localparam int PIXEL_COUNT = IMAGE_SIDE * IMAGE_SIDE;
    localparam int SIG_LEN     = 10;
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_BYTES   = PAL_ENTRIES * 4;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);
    localparam int PIX_W       = $clog2(PIXEL_COUNT);
    localparam int PAL_W       = $clog2(PAL_BYTES);
    localparam int POS_W       = (PIX_W > PAL_W) ? PIX_W : PAL_W;

    typedef enum logic [2:0] {
        PH_SIGNATURE,
        PH_TYPE,
        PH_PALETTE,
        PH_PIXELS,
        PH_ENDED,
        PH_HALTED
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PIXEL    = 2'd0,
        KIND_END      = 2'd1,
        KIND_BAD_SIG  = 2'd2,
        KIND_BAD_TYPE = 2'd3
    } t_kind;

    // Expected signature byte at each header position
    function automatic logic [7:0] sig_byte(input logic [3:0] idx);
        logic [7:0] val;
        case (idx)
            4'd0:    val = 8'h4A;
            4'd1:    val = 8'h4C;
            4'd2:    val = 8'h56;
            4'd3:    val = 8'h4D;
            4'd4:    val = 8'h30;
            4'd5:    val = 8'h3A;
            4'd6:    val = 8'h4A;
            4'd7:    val = 8'h59;
            4'd8:    val = 8'h4D;
            4'd9:    val = 8'h4A;
            default: val = 8'h4A;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

/* rtl/palette_image_stream_decoder.sv */
// Top level of the palette image stream decoder: header parser, palette store and pixel output.
`default_nettype none

// The block takes an image file one byte per transaction on the slave stream and
// accepts a byte in every cycle while the output side keeps up, so the sustained
// rate is one byte per cycle. Each image is a ten-byte signature, a type byte
// (1 to 3), 1024 palette bytes (red, green, blue, alpha per entry) and then
// IMAGE_SIDE squared index bytes; the next image follows the last index byte
// directly. Header and palette bytes give no output. Each index byte gives one
// pixel transaction on the master stream through the registered palette RAM
// read and then the output register. The palette lives in a 256 x 32 RAM,
// written once per entry on its fourth byte and read once per index byte;
// reads and writes never fall in the same image phase, so no forwarding is
// required. A zero byte in place of an image's first byte gives one "no more
// images" transaction; a signature mismatch or a type outside 1..3 gives one
// error transaction. After any of these the block keeps accepting bytes but
// drops them until reset. Backpressure on the master side stalls the read
// stage and then the slave side; no transaction is lost or repeated.

module palette_image_stream_decoder
    import psd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast    // last_pixel
);

    // parser state
    t_phase            r_phase, n_phase;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_mis, n_mis;
    logic [23:0]       r_partial, n_partial;

    // read stage (waits for palette RAM data)
    logic              r_s1_valid;
    t_kind             r_s1_kind;
    logic              r_s1_last;

    // output register
    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [31:0]       r_out_data;
    logic              r_out_last;

    logic              accept;
    logic              out_ready;
    logic              s1_free;
    logic              emit;
    t_kind             emit_kind;
    logic              emit_last;
    logic              sig_mis_now;

    logic              ram_we;
    logic              ram_re;
    logic [31:0]       ram_rdata;

    // Advance the read stage when the output register is free or being emptied
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign s1_free       = !r_s1_valid || out_ready;
    assign s_axis_tready = s1_free;
    assign accept        = s_axis_tvalid && s1_free;

    assign sig_mis_now = (s_axis_tdata != sig_byte(r_pos[3:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SIGNATURE;
            r_pos     <= '0;
            r_mis     <= 1'b0;
            r_partial <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_mis     <= n_mis;
            r_partial <= n_partial;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_mis     = r_mis;
        n_partial = r_partial;
        emit      = 1'b0;
        emit_kind = KIND_PIXEL;
        emit_last = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        if (accept) begin
            case (r_phase)
                PH_SIGNATURE: begin
                    if (r_pos == '0 && s_axis_tdata == 8'd0) begin
                        // end-of-images marker
                        n_phase   = PH_ENDED;
                        emit      = 1'b1;
                        emit_kind = KIND_END;
                    end else begin
                        n_mis = ((r_pos == '0) ? 1'b0 : r_mis) | sig_mis_now;
                        if (r_pos == POS_W'(SIG_LEN - 1)) begin
                            n_pos = '0;
                            if (n_mis) begin
                                n_phase   = PH_HALTED;
                                emit      = 1'b1;
                                emit_kind = KIND_BAD_SIG;
                            end else begin
                                n_phase = PH_TYPE;
                            end
                        end else begin
                            n_pos = r_pos + POS_W'(1);
                        end
                    end
                end
                PH_TYPE: begin
                    n_pos = '0;
                    if (s_axis_tdata < 8'd1 || s_axis_tdata > 8'd3) begin
                        n_phase   = PH_HALTED;
                        emit      = 1'b1;
                        emit_kind = KIND_BAD_TYPE;
                    end else begin
                        n_phase   = PH_PALETTE;
                        n_partial = '0;
                    end
                end
                PH_PALETTE: begin
                    // collect red, green, blue; write the entry on its alpha byte
                    if (r_pos[1:0] == 2'd3) begin
                        ram_we    = 1'b1;
                        n_partial = '0;
                    end else begin
                        n_partial = {r_partial[15:0], s_axis_tdata};
                    end
                    if (r_pos == POS_W'(PAL_BYTES - 1)) begin
                        n_pos   = '0;
                        n_phase = PH_PIXELS;
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end
                PH_PIXELS: begin
                    ram_re    = 1'b1;
                    emit      = 1'b1;
                    emit_kind = KIND_PIXEL;
                    if (r_pos == POS_W'(PIXEL_COUNT - 1)) begin
                        emit_last = 1'b1;
                        n_pos     = '0;
                        n_phase   = PH_SIGNATURE;
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end
                default: begin
                    // ended or halted: drop the byte
                end
            endcase
        end
    end

    psd_ram #(
        .WIDTH (32),
        .DEPTH (PAL_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos[PAL_AW+1:2]),
        .i_wdata ({r_partial, s_axis_tdata}),
        .i_re    (ram_re),
        .i_raddr (s_axis_tdata[PAL_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind <= emit_kind;
            r_s1_last <= emit_last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid) begin
            r_out_kind <= r_s1_kind;
            r_out_last <= r_s1_last;
            // RAM holds red in the top byte; the stream carries red lowest
            if (r_s1_kind == KIND_PIXEL) begin
                r_out_data <= {ram_rdata[7:0], ram_rdata[15:8],
                               ram_rdata[23:16], ram_rdata[31:24]};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    // Once ended or halted, an accepted byte never produces a transaction
    a_drop_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_phase == PH_ENDED || r_phase == PH_HALTED)) |=> !r_s1_valid)
        else $error("transaction produced after the stream was stopped");

    // Pixel counter stays inside the image
    a_pixel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXELS) |-> (r_pos <= POS_W'(PIXEL_COUNT - 1)))
        else $error("pixel position beyond image size");

    // Signature counter stays inside the signature
    a_sig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SIGNATURE) |-> (r_pos <= POS_W'(SIG_LEN - 1)))
        else $error("signature position beyond signature length");

    // A stalled pixel keeps its palette data
    a_hold_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_kind == KIND_PIXEL && !out_ready) |=> $stable(ram_rdata))
        else $error("palette read data changed under a stalled pixel");

    // Palette writes and pixel reads never coincide
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !(r_s1_valid && r_s1_kind == KIND_PIXEL && !out_ready))
        else $error("palette write while a pixel read is pending");

endmodule

`default_nettype wire

/* rtl/psd_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module psd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the read data while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* tb/palette_image_stream_decoder_tb.sv */
// Self-checking testbench for the palette image stream decoder: header, palette and a pixel run.
`default_nettype none

module palette_image_stream_decoder_tb;
    import psd_pkg::*;

    // Signature of an image, first byte in the low bits
    localparam logic [8*SIG_LEN-1:0] MAGIC = {8'h4A, 8'h4D, 8'h59, 8'h4A, 8'h3A,
                                              8'h30, 8'h4D, 8'h56, 8'h4C, 8'h4A};
    localparam int QUIET_LIMIT  = 5000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES = 16;    // well past the pixel path through read stage and output register
    localparam int PIXELS_SENT  = 960;   // with header and palette, about 2000 bytes
    localparam int PHASE_BYTES  = 250;   // bytes per idling phase

    typedef enum int {
        MODE_FREE,
        MODE_SEND_GAPS,
        MODE_RECV_STALLS,
        MODE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [7:0] data;
        bit         hold;   // offer only once every pixel has been returned
    } t_file_byte;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_pixel;
    } t_decoded;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;    // [7:0] data_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;            // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    logic [1:0]  m_axis_tuser;            // [1:0] kind
    logic        m_axis_tlast;            // last_pixel

    palette_image_stream_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    t_file_byte file_bytes[$];
    t_decoded   decoded_due[$];
    int         bytes_in    = 0;
    int         mismatches  = 0;
    int         quiet_count = 0;

    // Shadow of the decoder state
    t_phase           dec_phase   = PH_SIGNATURE;
    logic [POS_W-1:0] dec_pos     = '0;
    logic             dec_sig_bad = 1'b0;
    logic [23:0]      dec_partial = '0;
    logic [31:0]      dec_palette [PAL_ENTRIES];

    function automatic void push_result(t_kind kind, logic [31:0] rgba, logic last_pixel);
        t_decoded r;
        r.kind       = kind;
        r.red        = rgba[31:24];
        r.green      = rgba[23:16];
        r.blue       = rgba[15:8];
        r.alpha      = rgba[7:0];
        r.last_pixel = last_pixel;
        decoded_due.push_back(r);
    endfunction

    // Advance the shadow state by one file byte and queue any pixel or status it yields
    function automatic void decode_byte(logic [7:0] b);
        case (dec_phase)
            PH_SIGNATURE: begin
                if (dec_pos == '0 && b == 8'd0) begin
                    dec_phase = PH_ENDED;
                    push_result(KIND_END, 32'd0, 1'b0);
                end else begin
                    if (dec_pos == '0)
                        dec_sig_bad = 1'b0;
                    if (b != MAGIC[8*dec_pos +: 8])
                        dec_sig_bad = 1'b1;
                    dec_pos = dec_pos + POS_W'(1);
                    if (dec_pos == POS_W'(SIG_LEN)) begin
                        dec_pos = '0;
                        if (dec_sig_bad) begin
                            dec_phase = PH_HALTED;
                            push_result(KIND_BAD_SIG, 32'd0, 1'b0);
                        end else begin
                            dec_phase = PH_TYPE;
                        end
                    end
                end
            end
            PH_TYPE: begin
                dec_pos = '0;
                if (b < 8'd1 || b > 8'd3) begin
                    dec_phase = PH_HALTED;
                    push_result(KIND_BAD_TYPE, 32'd0, 1'b0);
                end else begin
                    dec_phase   = PH_PALETTE;
                    dec_partial = '0;
                end
            end
            PH_PALETTE: begin
                if (dec_pos[1:0] == 2'd3) begin
                    dec_palette[dec_pos[PAL_AW+1:2]] = {dec_partial, b};
                    dec_partial = '0;
                end else begin
                    dec_partial = {dec_partial[15:0], b};
                end
                dec_pos = dec_pos + POS_W'(1);
                if (dec_pos == POS_W'(PAL_BYTES)) begin
                    dec_pos   = '0;
                    dec_phase = PH_PIXELS;
                end
            end
            PH_PIXELS: begin
                if (dec_pos == POS_W'(PIXEL_COUNT - 1)) begin
                    push_result(KIND_PIXEL, dec_palette[b], 1'b1);
                    dec_pos   = '0;
                    dec_phase = PH_SIGNATURE;
                end else begin
                    push_result(KIND_PIXEL, dec_palette[b], 1'b0);
                    dec_pos = dec_pos + POS_W'(1);
                end
            end
            default: ;
        endcase
    endfunction

    // Step through the idling phases as the stream advances
    function automatic t_idle_mode idle_mode();
        return t_idle_mode'((bytes_in / PHASE_BYTES) % 4);
    endfunction

    function automatic bit offer_now();
        t_idle_mode m;
        m = idle_mode();
        if (file_bytes[0].hold && decoded_due.size() != 0)
            return 1'b0;
        if (m == MODE_SEND_GAPS)
            return $urandom_range(99) >= 54;
        if (m == MODE_BOTH)
            return $urandom_range(99) >= 13;
        return 1'b1;
    endfunction

    function automatic bit take_now();
        t_idle_mode m;
        m = idle_mode();
        if (m == MODE_RECV_STALLS)
            return $urandom_range(99) >= 54;
        if (m == MODE_BOTH)
            return $urandom_range(99) >= 13;
        return 1'b1;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void queue_byte(logic [7:0] b, bit hold = 1'b0);
        t_file_byte fb;
        fb.data = b;
        fb.hold = hold;
        file_bytes.push_back(fb);
    endfunction

    // Hold tvalid until the transaction completes, then offer the next byte or go idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata);
                bytes_in <= bytes_in + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (file_bytes.size() != 0 && offer_now()) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= file_bytes[0].data;
                    void'(file_bytes.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Compare every returned transaction with the oldest outstanding one
    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (decoded_due.size() == 0) begin
                    $error("unexpected result: kind %0d data %h last %0b",
                           m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end else begin
                    want = decoded_due.pop_front();
                    check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                    check_field("red", 32'(want.red), 32'(m_axis_tdata[7:0]));
                    check_field("green", 32'(want.green), 32'(m_axis_tdata[15:8]));
                    check_field("blue", 32'(want.blue), 32'(m_axis_tdata[23:16]));
                    check_field("alpha", 32'(want.alpha), 32'(m_axis_tdata[31:24]));
                    check_field("last_pixel", 32'(want.last_pixel), 32'(m_axis_tlast));
                end
            end
            m_axis_tready <= take_now();
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_count <= 0;
            end else if (quiet_count >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                quiet_count <= quiet_count + 1;
            end
        end
    end

    initial begin
        logic [31:0] entry;

        // Image header with a legal type
        for (int i = 0; i < SIG_LEN; i++)
            queue_byte(MAGIC[8*i +: 8]);
        queue_byte(8'($urandom_range(1, 3)));

        // Palette: extremes on a few entries, random elsewhere
        for (int e = 0; e < PAL_ENTRIES; e++) begin
            case (e)
                0:       entry = 32'h0000_0000;
                1:       entry = 32'h0102_0304;
                128:     entry = 32'h8000_0001;
                255:     entry = 32'hFFFF_FFFF;
                default: entry = $urandom;
            endcase
            for (int k = 3; k >= 0; k--)
                queue_byte(entry[8*k +: 8]);
        end

        // Pixels: corner indexes first, then random, one pause to drain mid-stream
        queue_byte(8'd0);
        queue_byte(8'd255);
        queue_byte(8'd1);
        queue_byte(8'd128);
        queue_byte(8'h55);
        queue_byte(8'hAA);
        for (int p = 6; p < PIXELS_SENT; p++)
            queue_byte(8'($urandom_range(255)), p == 600);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (file_bytes.size() != 0 || s_axis_tvalid || decoded_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && decoded_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
